>>> hw/rtl/gcd_pkg.sv
// ---------------------------------------------------------------------------
// gcd_pkg
// Shared sizes, codes and types of the greedy change dispenser.
// ---------------------------------------------------------------------------
package gcd_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int VALUE_BITS  = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_REPORT  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      total_t;

  typedef struct packed {
    value_t      value;
    logic [15:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CHK,
    S_LD_PUT,
    S_RQ_RD,
    S_RQ_LAT,
    S_RQ_DIV,
    S_RQ_END,
    S_RP_RD,
    S_RP_OUT
  } state_t;

  function automatic value_t to_value(logic [15:0] x);
    logic [VALUE_BITS+15:0] ext;
    ext = {{VALUE_BITS{1'b0}}, x};
    return ext[VALUE_BITS-1:0];
  endfunction

  function automatic logic [15:0] from_value(value_t v);
    logic [VALUE_BITS+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

endpackage

>>> hw/rtl/greedy_change_dispenser_core.sv
// ---------------------------------------------------------------------------
// greedy_change_dispenser_core
// Coin table with greedy payout, sorted insert and inventory report.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. action selects load,
// change request or report; action 3 is dropped with no result.
// Results appear on status/out_value/out_count/remainder/last for one cycle
// with strobe high; last marks the final result of a request. The receiver
// cannot stall, so every result is shown exactly once.
// Sequencing: a rejected load, a load into a full table, an empty report and
// an unknown action finish in the accept cycle; the result of the first three
// is registered and shows in the next cycle. A load walks the table from the
// tail, shifting each entry whose value is not above the new one a place back,
// then writes the new entry. A report shows each entry in turn. A request
// visits entries until the amount is zero or the table ends (memory read,
// latch, one 16-step restoring division, its done cycle with the update). The
// table lives in one memory with a registered read port, so accesses are
// strictly sequenced. Reset empties the table; no clearing pass is needed.
// ---------------------------------------------------------------------------
module greedy_change_dispenser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] coin_value,
  input  logic [15:0] coin_count,
  input  logic [15:0] amount,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [15:0] out_value,
  output logic [15:0] out_count,
  output logic [15:0] remainder,
  output logic        last
);
  import gcd_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rdata;
  idx_t   raddr;
  idx_t   waddr;
  entry_t wdata;
  logic   we;

  state_t      state, state_next;
  total_t      idx, idx_next;
  total_t      total, total_next;
  logic [15:0] amt, amt_next;
  entry_t      cur, cur_next;
  entry_t      nw, nw_next;
  entry_t      pend, pend_next;
  logic        pend_valid, pend_valid_next;

  logic        emit;
  logic [1:0]  emit_status;
  logic [15:0] emit_value;
  logic [15:0] emit_count;
  logic [15:0] emit_rem;
  logic        emit_last;

  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] got;
  logic [VALUE_BITS+15:0] prod;
  value_t      in_value;

  gcd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (amt),
    .divisor  (rdata.value),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign busy     = (state != S_IDLE);
  assign in_value = to_value(coin_value);
  assign got      = (div_q < cur.count) ? div_q : cur.count;
  assign prod     = cur.value * got;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    total_next      = total;
    amt_next        = amt;
    cur_next        = cur;
    nw_next         = nw;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    raddr           = idx[IDX_W-1:0];
    waddr           = idx[IDX_W-1:0];
    wdata           = nw;
    we              = 1'b0;
    div_start       = 1'b0;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_value      = '0;
    emit_count      = '0;
    emit_rem        = '0;
    emit_last       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_LOAD: begin
              nw_next = '{value: in_value, count: coin_count};
              if (in_value == '0 || total == total_t'(MAX_ENTRIES)) begin
                emit        = 1'b1;
                emit_status = (in_value == '0) ? ST_ZERO : ST_FULL;
                emit_value  = coin_value;
                emit_count  = coin_count;
                emit_last   = 1'b1;
              end else begin
                idx_next   = total;
                state_next = S_LD_RD;
              end
            end
            ACT_REQUEST: begin
              amt_next        = amount;
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = S_RQ_RD;
            end
            ACT_REPORT: begin
              idx_next = '0;
              if (total == '0) begin
                emit      = 1'b1;
                emit_last = 1'b1;
              end else begin
                state_next = S_RP_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_LD_RD: begin
        raddr = idx[IDX_W-1:0] - idx_t'(1);
        state_next = (idx == '0) ? S_LD_PUT : S_LD_CHK;
      end

      S_LD_CHK: begin
        if (rdata.value > nw.value) begin
          state_next = S_LD_PUT;
        end else begin
          we         = 1'b1;
          wdata      = rdata;
          idx_next   = idx - total_t'(1);
          state_next = S_LD_RD;
        end
      end

      S_LD_PUT: begin
        we          = 1'b1;
        wdata       = nw;
        total_next  = total + total_t'(1);
        emit        = 1'b1;
        emit_status = ST_OK;
        emit_value  = from_value(nw.value);
        emit_count  = nw.count;
        emit_last   = 1'b1;
        state_next  = S_IDLE;
      end

      S_RQ_RD: begin
        if (idx == total || amt == '0) begin
          state_next = S_RQ_END;
        end else begin
          state_next = S_RQ_LAT;
        end
      end

      S_RQ_LAT: begin
        cur_next = rdata;
        if (rdata.value == '0) begin
          idx_next   = idx + total_t'(1);
          state_next = S_RQ_RD;
        end else begin
          div_start  = 1'b1;
          state_next = S_RQ_DIV;
        end
      end

      S_RQ_DIV: begin
        if (div_done) begin
          we       = 1'b1;
          wdata    = '{value: cur.value, count: cur.count - got};
          amt_next = amt - prod[15:0];
          if (got != '0) begin
            if (pend_valid) begin
              emit       = 1'b1;
              emit_value = from_value(pend.value);
              emit_count = pend.count;
            end
            pend_next       = '{value: cur.value, count: got};
            pend_valid_next = 1'b1;
          end
          idx_next   = idx + total_t'(1);
          state_next = S_RQ_RD;
        end
      end

      S_RQ_END: begin
        emit       = 1'b1;
        emit_rem   = amt;
        emit_last  = 1'b1;
        if (pend_valid) begin
          emit_value = from_value(pend.value);
          emit_count = pend.count;
        end
        state_next = S_IDLE;
      end

      S_RP_RD: begin
        state_next = S_RP_OUT;
      end

      S_RP_OUT: begin
        emit       = 1'b1;
        emit_value = from_value(rdata.value);
        emit_count = rdata.count;
        emit_last  = (idx + total_t'(1) == total);
        idx_next   = idx + total_t'(1);
        state_next = emit_last ? S_IDLE : S_RP_RD;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      total      <= total_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
      strobe     <= emit;
    end
  end

  always_ff @(posedge clk) begin
    amt       <= amt_next;
    cur       <= cur_next;
    nw        <= nw_next;
    pend      <= pend_next;
    status    <= emit_status;
    out_value <= emit_value;
    out_count <= emit_count;
    remainder <= emit_rem;
    last      <= emit_last;
  end

endmodule

>>> hw/rtl/gcd_divider.sv
// ---------------------------------------------------------------------------
// gcd_divider
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ---------------------------------------------------------------------------
module gcd_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [15:0]    dividend,
  input  gcd_pkg::value_t divisor,
  output logic           done,
  output logic [15:0]    quotient
);
  import gcd_pkg::*;

  logic                  run;
  logic [3:0]            step;
  value_t                rem;
  value_t                dsr;
  logic [15:0]           dvd;
  logic [VALUE_BITS:0]   rem_sh;
  logic [VALUE_BITS:0]   diff;
  logic                  qbit;
  value_t                rem_next;

  always_comb begin
    rem_sh   = {rem, dvd[15]};
    diff     = rem_sh - {1'b0, dsr};
    qbit     = (rem_sh >= {1'b0, dsr});
    rem_next = qbit ? diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (run) begin
        rem      <= rem_next;
        dvd      <= {dvd[14:0], 1'b0};
        quotient <= {quotient[14:0], qbit};
        step     <= step + 4'd1;
        if (step == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
